FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the bump detector RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, quiet while reset is asserted.
`define SBD_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SBD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/sbd_pkg.sv
// ---------------------------------------------------------------------------
// sbd_pkg
// Types and constants of the suspension bump detector.
// ---------------------------------------------------------------------------
package sbd_pkg;

  localparam int unsigned TimeW  = 20;
  localparam int unsigned VelW   = 16;
  localparam int unsigned DispW  = 16;
  localparam int unsigned DtW    = 16;
  localparam int unsigned CntW   = 21;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 20;

  // Reset values of the configuration registers.
  localparam logic [TimeW-1:0]        DisplaceTimeRst  = 20'd10000;
  localparam logic signed [VelW-1:0]  DisplaceVelRst   = 16'sd128;  // 0.5 in Q8.8
  localparam logic [TimeW-1:0]        SettleTimeRst    = 20'd10000;
  localparam logic signed [VelW-1:0]  SettleVelRst     = 16'sd0;    // 0.0 in Q8.8

  typedef enum logic [1:0] {
    PH_SETTLED    = 2'd0,
    PH_DISPLACING = 2'd1,
    PH_DISPLACED  = 2'd2,
    PH_SETTLING   = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DISPLACE_TIME = 2'd0,
    CFG_DISPLACE_VEL  = 2'd1,
    CFG_SETTLE_TIME   = 2'd2,
    CFG_SETTLE_VEL    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [VelW-1:0] velocity;
    logic [DispW-1:0]       displacement;
    logic [DtW-1:0]         elapsed_us;
  } in_t;

  typedef struct packed {
    phase_e           phase;
    phase_e           prev_phase;
    logic [DispW-1:0] bump_start;
    logic [DispW-1:0] bump_end;
  } out_t;

endpackage

FILE: rtl/suspension_bump_detector_core.sv
// ---------------------------------------------------------------------------
// suspension_bump_detector_core
// Four-phase bump detector for one suspension sensor sample stream.
// ---------------------------------------------------------------------------
// The block takes one sample per cycle while its input side is not stalled
// and returns exactly one result per sample. A sample is first captured in
// an input register; a single pass of compare and subtract logic then moves
// the phase on the velocity limits, runs the countdown of the resulting
// phase and updates the bump captures, and the result lands in a two-entry
// output buffer (result register plus skid register). The sustained rate is
// one sample per cycle while results are taken, set by that phase update,
// whose state feeds straight back into the next sample. The input side
// stalls only while the input register is full and both output entries hold
// results that have not yet been taken. Phases are 0 settled, 1 displacing,
// 2 displaced, 3 settling. Configuration writes take effect at once and are
// meant to be made while the block is idle.
`include "assert_macros.svh"

module suspension_bump_detector_core
  import sbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Sample channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // Configuration registers.
  logic [TimeW-1:0]       displace_time_q;
  logic signed [VelW-1:0] displace_vel_q;
  logic [TimeW-1:0]       settle_time_q;
  logic signed [VelW-1:0] settle_vel_q;

  // Detector state.
  phase_e                 phase_q, phase_d;
  logic signed [CntW-1:0] dcnt_q, dcnt_d;
  logic signed [CntW-1:0] scnt_q, scnt_d;
  logic [DispW-1:0]       start_q, start_d;
  logic [DispW-1:0]       end_q, end_d;

  // Input register and output buffer.
  logic s1_valid_q;
  in_t  s1_q;
  logic out_valid_q, skid_valid_q;
  out_t out_q, skid_q;
  out_t result;

  logic in_xfer, s1_adv, out_pop;

  assign out_pop    = out_valid_q && !out_stall_i;
  // The step runs whenever a sample waits and the skid entry is free, so a
  // result always has a place to go.
  assign s1_adv     = s1_valid_q && !skid_valid_q;
  assign in_stall_o = s1_valid_q && skid_valid_q;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      displace_time_q <= DisplaceTimeRst;
      displace_vel_q  <= DisplaceVelRst;
      settle_time_q   <= SettleTimeRst;
      settle_vel_q    <= SettleVelRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DISPLACE_TIME: displace_time_q <= cfg_wdata_i[TimeW-1:0];
        CFG_DISPLACE_VEL:  displace_vel_q  <= cfg_wdata_i[VelW-1:0];
        CFG_SETTLE_TIME:   settle_time_q   <= cfg_wdata_i[TimeW-1:0];
        CFG_SETTLE_VEL:    settle_vel_q    <= cfg_wdata_i[VelW-1:0];
        default: ;
      endcase
    end
  end

  // One step of the detector on the sample in the input register.
  always_comb begin
    phase_e                 ph_vel;
    logic signed [CntW-1:0] dt;
    logic signed [CntW-1:0] dbase;
    logic signed [CntW-1:0] dnext;
    logic signed [CntW-1:0] snext;
    logic                   dload;

    phase_d = phase_q;
    dcnt_d  = dcnt_q;
    scnt_d  = scnt_q;
    start_d = start_q;
    end_d   = end_q;
    ph_vel  = phase_q;
    dload   = 1'b0;
    dt      = signed'({{(CntW-DtW){1'b0}}, s1_q.elapsed_us});

    // Velocity moves come first.
    unique case (phase_q)
      PH_SETTLED: begin
        if (s1_q.velocity >= displace_vel_q) begin
          ph_vel  = PH_DISPLACING;
          dload   = 1'b1;
          start_d = s1_q.displacement;
        end
      end
      PH_DISPLACING: begin
        if (s1_q.velocity < displace_vel_q) ph_vel = PH_SETTLED;
      end
      PH_DISPLACED: begin
        if (s1_q.velocity <= settle_vel_q) ph_vel = PH_SETTLING;
      end
      PH_SETTLING: begin
        if (s1_q.velocity > settle_vel_q) ph_vel = PH_DISPLACED;
      end
      default: ;
    endcase

    // A fresh displacing phase loads its countdown and runs it in the same
    // step, so a zero confirm time passes straight to displaced.
    dbase = dload ? signed'({{(CntW-TimeW){1'b0}}, displace_time_q}) : dcnt_q;
    dnext = dbase - dt;
    snext = scnt_q - dt;
    phase_d = ph_vel;

    unique case (ph_vel)
      PH_DISPLACING: begin
        dcnt_d = dnext;
        if (dnext[CntW-1] || dnext == '0) begin
          phase_d = PH_DISPLACED;
          scnt_d  = signed'({{(CntW-TimeW){1'b0}}, settle_time_q});
        end
      end
      PH_SETTLING: begin
        scnt_d = snext;
        if (snext[CntW-1] || snext == '0) begin
          phase_d = PH_SETTLED;
          end_d   = s1_q.displacement;
        end
      end
      default: ;
    endcase

    result.phase      = phase_d;
    result.prev_phase = phase_q;
    result.bump_start = start_d;
    result.bump_end   = end_d;
  end

  // Input register and detector state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= PH_SETTLED;
      dcnt_q     <= '0;
      scnt_q     <= '0;
      start_q    <= '0;
      end_q      <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        phase_q <= phase_d;
        dcnt_q  <= dcnt_d;
        scnt_q  <= scnt_d;
        start_q <= start_d;
        end_q   <= end_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_data_i;
    end
  end

  // Two-entry output buffer: the result register is the head, the skid
  // register holds a second result while the head is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (out_pop && skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (out_pop) begin
        out_valid_q <= s1_adv;
      end else if (s1_adv && !out_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (s1_adv) begin
        skid_valid_q <= 1'b1;
      end else begin
        // Nothing enters or leaves the buffer this cycle.
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (out_pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if (s1_adv && (out_pop || !out_valid_q)) begin
      out_q <= result;
    end else if (s1_adv) begin
      skid_q <= result;
    end else begin
      // Both entries keep their contents.
    end
  end

  // A held result in the skid register always sits behind a valid head.
  `SBD_ASSERT_ALWAYS(a_skid_behind_head, clk_i, skid_valid_q |-> out_valid_q, "skid without head")
  // A sample in the input register that cannot advance is never dropped.
  `SBD_ASSERT(a_s1_held, clk_i, rst_ni, (s1_valid_q && !s1_adv) |=> s1_valid_q, "sample lost")
  // Staying in displacing or settling means the countdown has not run out.
  `SBD_ASSERT(a_dcnt_live, clk_i, rst_ni, (phase_q == PH_DISPLACING) |-> (dcnt_q > 0), "dcnt spent")
  `SBD_ASSERT(a_scnt_live, clk_i, rst_ni, (phase_q == PH_SETTLING) |-> (scnt_q > 0), "scnt spent")
  // The phase moves only when a sample is processed.
  `SBD_ASSERT(a_phase_hold, clk_i, rst_ni, !s1_adv |=> $stable(phase_q), "phase moved idle")

endmodule
